// File: sv/wepm_pkg.sv
// ----------------------------------------------------------------------------
// wepm_pkg
// Shared types for the watch entry pool manager: request and result payloads,
// command and status codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package wepm_pkg;

  // Pool size and entry value width
  localparam int POOL_ENTRIES = 32;
  localparam int VALUE_BITS   = 32;
  localparam int ID_BITS      = $clog2(POOL_ENTRIES);

  // Command codes carried in the request
  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_FIND    = 3'd2,
    CMD_CHECK   = 3'd3,
    CMD_LIST    = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EXHAUSTED  = 2'd1,
    ST_NOT_IN_USE = 2'd2,
    ST_LIST_EMPTY = 2'd3
  } status_e;

  // One request
  typedef struct packed {
    logic [2:0]            cmd;
    logic [ID_BITS-1:0]    entry_id;
    logic [VALUE_BITS-1:0] data_value;
    logic                  value_ok;
  } req_t;

  // One result
  typedef struct packed {
    logic [1:0]            status;
    logic [ID_BITS-1:0]    result_id;
    logic [VALUE_BITS-1:0] stored_value;
    logic                  changed;
    logic                  last;
  } rsp_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EMIT_ERR,
    S_ALLOC_UPD,
    S_ALLOC_LINK,
    S_ACCESS,
    S_REL_WALK,
    S_REL_FIN,
    S_LIST_EMIT
  } state_e;

  // Address source for the link/value memory reads and the cursor
  typedef enum logic [1:0] {
    RD_FREE_HEAD,
    RD_REQ_ID,
    RD_USED_HEAD,
    RD_LINK
  } rd_src_e;

  // Link memory write selection
  typedef enum logic [2:0] {
    LW_NONE,
    LW_SELF_CLEAR,
    LW_TAIL,
    LW_UNLINK,
    LW_PUSH
  } lw_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic    req_ld;
    logic    rd_link;
    logic    rd_val;
    rd_src_e rd_src;
    logic    cur_ld;
    logic    nxt_ld;
    lw_sel_e lw_sel;
    logic    val_we;
    logic    alloc_a;
    logic    alloc_b;
    logic    rel_head;
    logic    rel_unlink;
    logic    rel_fin;
    logic    k_clr;
    logic    k_inc;
    logic    out_ld;
    status_e out_status;
    logic    list_mode;
    logic    chk_mode;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] cmd;
    logic       value_ok;
    logic       id_valid;
    logic       free_empty;
    logic       used_empty;
    logic       head_is_cur;
    logic       link_is_cur;
    logic       list_last;
    logic       out_free;
  } sts_t;

endpackage

// File: sv/wepm_datapath.sv
// ----------------------------------------------------------------------------
// wepm_datapath
// Entry storage (link and value memories, in-use flags), list pointers and
// counts, the cursor used for walks, and the result output register.
// ----------------------------------------------------------------------------
module wepm_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wepm_pkg::req_t in_req_i,
  input  wepm_pkg::ctl_t ctl_i,
  output wepm_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output wepm_pkg::rsp_t out_rsp_o
);
  import wepm_pkg::*;

  localparam int IDW = ID_BITS;
  localparam int CW  = $clog2(POOL_ENTRIES + 1);

  // Request and walk registers
  req_t                  req_q;
  logic [IDW-1:0]        cur_q;
  logic [IDW-1:0]        nxt_q;
  logic [CW-1:0]         k_q;

  // List pointers and counts
  logic [IDW-1:0]        free_head_q;
  logic [CW-1:0]         free_cnt_q;
  logic [IDW-1:0]        used_head_q;
  logic [IDW-1:0]        used_tail_q;
  logic [CW-1:0]         used_cnt_q;
  logic [POOL_ENTRIES-1:0] in_use_q;

  // Link memory with per-entry written bits; unwritten entries link to i+1, the last one to 0
  logic [IDW-1:0]        link_mem [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] link_vld_q;
  logic [IDW-1:0]        link_rd_q;
  logic                  link_rd_vld_q;
  logic [IDW-1:0]        rd_addr_q;
  logic [IDW-1:0]        link_nxt;

  // Value memory
  logic [VALUE_BITS-1:0] val_mem [POOL_ENTRIES];
  logic [VALUE_BITS-1:0] val_rd_q;
  logic [VALUE_BITS-1:0] wval;

  // Output register
  logic                  out_valid_q;
  rsp_t                  out_rsp_q;
  logic                  out_free;

  logic [IDW-1:0]        req_id;
  logic [IDW-1:0]        rd_addr;
  logic                  lw_en;
  logic [IDW-1:0]        lw_addr;
  logic [IDW-1:0]        lw_data;
  logic                  list_last;
  rsp_t                  rsp_d;

  assign req_id = IDW'(req_q.entry_id);
  assign wval   = VALUE_BITS'(req_q.data_value);

  // Resolve the registered link read, falling back to the reset chain
  always_comb begin
    if (link_rd_vld_q) begin
      link_nxt = link_rd_q;
    end else if (rd_addr_q == IDW'(POOL_ENTRIES - 1)) begin
      link_nxt = '0;
    end else begin
      link_nxt = rd_addr_q + IDW'(1);
    end
  end

  // Select the read address (also loads the cursor)
  always_comb begin
    case (ctl_i.rd_src)
      RD_FREE_HEAD: rd_addr = free_head_q;
      RD_REQ_ID:    rd_addr = req_id;
      RD_USED_HEAD: rd_addr = used_head_q;
      RD_LINK:      rd_addr = link_nxt;
      default:      rd_addr = req_id;
    endcase
  end

  // Select the link write
  always_comb begin
    lw_en   = 1'b0;
    lw_addr = cur_q;
    lw_data = '0;
    case (ctl_i.lw_sel)
      LW_SELF_CLEAR: begin
        lw_en = 1'b1;
      end
      LW_TAIL: begin
        lw_en   = (used_cnt_q != '0);
        lw_addr = used_tail_q;
        lw_data = cur_q;
      end
      LW_UNLINK: begin
        lw_en   = 1'b1;
        lw_addr = rd_addr_q;
        lw_data = nxt_q;
      end
      LW_PUSH: begin
        lw_en   = 1'b1;
        lw_data = free_head_q;
      end
      default: lw_en = 1'b0;
    endcase
  end

  // Link memory array and registered read
  always_ff @(posedge clk_i) begin
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (ctl_i.rd_link) begin
      link_rd_q <= link_mem[rd_addr];
    end
  end

  // Track which entries have a written link and the last read address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q    <= '0;
      link_rd_vld_q <= 1'b0;
      rd_addr_q     <= '0;
    end else begin
      if (lw_en) begin
        link_vld_q[lw_addr] <= 1'b1;
      end
      if (ctl_i.rd_link) begin
        link_rd_vld_q <= link_vld_q[rd_addr];
        rd_addr_q     <= rd_addr;
      end
    end
  end

  // Value memory array and registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.val_we) begin
      val_mem[cur_q] <= wval;
    end
    if (ctl_i.rd_val) begin
      val_rd_q <= val_mem[rd_addr];
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (ctl_i.req_ld) begin
      req_q <= in_req_i;
    end
  end

  // Update list pointers, counts, flags and walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      free_cnt_q  <= CW'(POOL_ENTRIES);
      used_head_q <= '0;
      used_tail_q <= '0;
      used_cnt_q  <= '0;
      in_use_q    <= '0;
      cur_q       <= '0;
      nxt_q       <= '0;
      k_q         <= '0;
    end else begin
      if (ctl_i.cur_ld) begin
        cur_q <= rd_addr;
      end
      if (ctl_i.nxt_ld) begin
        nxt_q <= link_nxt;
      end
      if (ctl_i.k_clr) begin
        k_q <= '0;
      end else if (ctl_i.k_inc) begin
        k_q <= k_q + CW'(1);
      end
      // take the free head and mark it in use
      if (ctl_i.alloc_a) begin
        free_head_q     <= link_nxt;
        free_cnt_q      <= free_cnt_q - CW'(1);
        in_use_q[cur_q] <= 1'b1;
        if (used_cnt_q == '0) begin
          used_head_q <= cur_q;
        end
      end
      // append at the in-use tail
      if (ctl_i.alloc_b) begin
        used_tail_q <= cur_q;
        used_cnt_q  <= used_cnt_q + CW'(1);
      end
      // drop the entry from the in-use head
      if (ctl_i.rel_head) begin
        used_head_q <= link_nxt;
      end
      // bypass the entry inside the in-use list
      if (ctl_i.rel_unlink && (used_tail_q == cur_q)) begin
        used_tail_q <= rd_addr_q;
      end
      // push the entry on the free list
      if (ctl_i.rel_fin) begin
        used_cnt_q      <= used_cnt_q - CW'(1);
        free_head_q     <= cur_q;
        free_cnt_q      <= free_cnt_q + CW'(1);
        in_use_q[cur_q] <= 1'b0;
        if (used_cnt_q == CW'(1)) begin
          used_head_q <= '0;
          used_tail_q <= '0;
        end
      end
    end
  end

  assign list_last = ((k_q + CW'(1)) == used_cnt_q);

  // Build the result
  always_comb begin
    rsp_d        = '0;
    rsp_d.status = 2'(ctl_i.out_status);
    rsp_d.last   = !ctl_i.list_mode || list_last;
    if (ctl_i.out_status == ST_OK) begin
      rsp_d.result_id = cur_q;
      if (ctl_i.alloc_b) begin
        rsp_d.stored_value = wval;
      end else begin
        rsp_d.stored_value = val_rd_q;
      end
      rsp_d.changed = ctl_i.chk_mode && req_q.value_ok && (wval != val_rd_q);
    end else if (ctl_i.out_status == ST_NOT_IN_USE) begin
      rsp_d.result_id = req_q.entry_id;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  // Output register: hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_ld) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Status to the controller
  always_comb begin
    sts_o             = '0;
    sts_o.cmd         = req_q.cmd;
    sts_o.value_ok    = req_q.value_ok;
    sts_o.id_valid    = (32'(req_q.entry_id) < 32'(POOL_ENTRIES)) && in_use_q[req_id];
    sts_o.free_empty  = (free_cnt_q == '0);
    sts_o.used_empty  = (used_cnt_q == '0);
    sts_o.head_is_cur = (used_head_q == cur_q);
    sts_o.link_is_cur = (link_nxt == cur_q);
    sts_o.list_last   = list_last;
    sts_o.out_free    = out_free;
  end

endmodule

// File: sv/wepm_ctrl.sv
// ----------------------------------------------------------------------------
// wepm_ctrl
// Command sequencer: decodes the captured request and steps the datapath
// through allocate, release walk, find, check and list.
// ----------------------------------------------------------------------------
module wepm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  wepm_pkg::sts_t sts_i,
  output wepm_pkg::ctl_t ctl_o
);
  import wepm_pkg::*;

  state_e st_q;
  state_e st_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    st_d              = st_q;
    ctl_o             = '0;
    ctl_o.rd_src      = RD_REQ_ID;
    ctl_o.lw_sel      = LW_NONE;
    ctl_o.out_status  = ST_OK;
    in_stall_o        = 1'b1;
    case (st_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.req_ld = 1'b1;
          st_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.cmd)
          CMD_ALLOC: begin
            if (sts_i.free_empty) begin
              st_d = S_EMIT_ERR;
            end else begin
              ctl_o.rd_src  = RD_FREE_HEAD;
              ctl_o.rd_link = 1'b1;
              ctl_o.cur_ld  = 1'b1;
              st_d          = S_ALLOC_UPD;
            end
          end
          CMD_RELEASE, CMD_FIND, CMD_CHECK: begin
            if (!sts_i.id_valid) begin
              st_d = S_EMIT_ERR;
            end else begin
              ctl_o.rd_src  = RD_REQ_ID;
              ctl_o.rd_link = 1'b1;
              ctl_o.rd_val  = 1'b1;
              ctl_o.cur_ld  = 1'b1;
              st_d          = S_ACCESS;
            end
          end
          CMD_LIST: begin
            if (sts_i.used_empty) begin
              st_d = S_EMIT_ERR;
            end else begin
              ctl_o.rd_src  = RD_USED_HEAD;
              ctl_o.rd_link = 1'b1;
              ctl_o.rd_val  = 1'b1;
              ctl_o.cur_ld  = 1'b1;
              ctl_o.k_clr   = 1'b1;
              st_d          = S_LIST_EMIT;
            end
          end
          default: st_d = S_IDLE;
        endcase
      end
      S_EMIT_ERR: begin
        case (sts_i.cmd)
          CMD_ALLOC: ctl_o.out_status = ST_EXHAUSTED;
          CMD_LIST:  ctl_o.out_status = ST_LIST_EMPTY;
          default:   ctl_o.out_status = ST_NOT_IN_USE;
        endcase
        if (sts_i.out_free) begin
          ctl_o.out_ld = 1'b1;
          st_d         = S_IDLE;
        end
      end
      S_ALLOC_UPD: begin
        // take the free head, clear its link and store the value
        ctl_o.alloc_a = 1'b1;
        ctl_o.lw_sel  = LW_SELF_CLEAR;
        ctl_o.val_we  = 1'b1;
        st_d          = S_ALLOC_LINK;
      end
      S_ALLOC_LINK: begin
        if (sts_i.out_free) begin
          ctl_o.alloc_b = 1'b1;
          ctl_o.lw_sel  = LW_TAIL;
          ctl_o.out_ld  = 1'b1;
          st_d          = S_IDLE;
        end
      end
      S_ACCESS: begin
        case (sts_i.cmd)
          CMD_RELEASE: begin
            ctl_o.nxt_ld = 1'b1;
            if (sts_i.head_is_cur) begin
              ctl_o.rel_head = 1'b1;
              st_d           = S_REL_FIN;
            end else begin
              ctl_o.rd_src  = RD_USED_HEAD;
              ctl_o.rd_link = 1'b1;
              st_d          = S_REL_WALK;
            end
          end
          CMD_CHECK: begin
            if (sts_i.out_free) begin
              ctl_o.chk_mode = 1'b1;
              ctl_o.val_we   = sts_i.value_ok;
              ctl_o.out_ld   = 1'b1;
              st_d           = S_IDLE;
            end
          end
          default: begin
            if (sts_i.out_free) begin
              ctl_o.out_ld = 1'b1;
              st_d         = S_IDLE;
            end
          end
        endcase
      end
      S_REL_WALK: begin
        // follow links until the predecessor of the entry is found
        if (sts_i.link_is_cur) begin
          ctl_o.rel_unlink = 1'b1;
          ctl_o.lw_sel     = LW_UNLINK;
          st_d             = S_REL_FIN;
        end else begin
          ctl_o.rd_src  = RD_LINK;
          ctl_o.rd_link = 1'b1;
        end
      end
      S_REL_FIN: begin
        if (sts_i.out_free) begin
          ctl_o.rel_fin = 1'b1;
          ctl_o.lw_sel  = LW_PUSH;
          ctl_o.out_ld  = 1'b1;
          st_d          = S_IDLE;
        end
      end
      S_LIST_EMIT: begin
        // emit one entry a cycle while the output register is free, and read the next
        if (sts_i.out_free) begin
          ctl_o.out_ld    = 1'b1;
          ctl_o.list_mode = 1'b1;
          ctl_o.k_inc     = 1'b1;
          ctl_o.rd_src    = RD_LINK;
          ctl_o.rd_link   = 1'b1;
          ctl_o.rd_val    = 1'b1;
          ctl_o.cur_ld    = 1'b1;
          if (sts_i.list_last) begin
            st_d = S_IDLE;
          end
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

endmodule

// File: sv/watch_entry_pool_manager.sv
// ----------------------------------------------------------------------------
// watch_entry_pool_manager
// Pool of watch entries with a LIFO free list and an in-use list kept in
// allocation order. Commands: allocate, release, find, check value, list.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid_i/in_stall_o/in_req_i; results leave on
//   out_valid_o/out_stall_i/out_rsp_o. A request is taken when valid is high
//   and stall is low. One request is worked on at a time; in_stall_o is low
//   only while the sequencer is idle.
//   After accept, find, check and error cases give a single result;
//   allocate takes the free head and then links it at the in-use tail;
//   release walks the in-use list from its head, one link read per entry
//   walked before it, unless the entry is the head; list gives one result
//   per cycle while out_stall_i is low.
//   The next request is taken right after the last result is loaded; the
//   release walk and the list set the worst case.
//   The last flag marks the final result of each request.
//   Reset empties the in-use list and puts all entries on the free list in
//   order 0, 1, 2, ...; no clearing pass is needed.
//   While out_stall_i is high the result register holds and the sequencer
//   waits; no result is dropped.
// ----------------------------------------------------------------------------
module watch_entry_pool_manager (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  wepm_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output wepm_pkg::rsp_t out_rsp_o
);
  import wepm_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // Sequencer
  wepm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  // Storage and result register
  wepm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // A taken request keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while previous one still in progress");

  // A result is loaded only when the output register can take it
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_ld |-> sts.out_free)
    else $error("result loaded over a stalled result");

  // List updates never overlap
  a_one_list_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.alloc_a, ctl.alloc_b, ctl.rel_head, ctl.rel_unlink, ctl.rel_fin}))
    else $error("overlapping list pointer updates");

endmodule

// File: sim/watch_entry_pool_manager_chk.sv
// ----------------------------------------------------------------------------
// watch_entry_pool_manager_chk
// Watches the request and result channels of the watch entry pool manager,
// tracks the free list, the in-use order and the entry values, and compares
// every result that leaves the block with the oldest result still due.
// ----------------------------------------------------------------------------
module watch_entry_pool_manager_chk (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_stall_i,
  input  wepm_pkg::req_t req_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_stall_i,
  input  wepm_pkg::rsp_t rsp_i,
  output logic [31:0]    busy_mask_o,
  output int             pending_o,
  output int             checked_o,
  output int             mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wepm_pkg::*;

  localparam int ENTRIES      = 32;
  localparam int REPORT_LIMIT = 10;

  // Pool image: free stack head at index 0, in-use entries oldest first
  logic [4:0]  free_stack[$];
  logic [4:0]  alloc_order[$];
  logic [31:0] entry_val [ENTRIES];
  logic [31:0] entry_busy;
  rsp_t        results_due[$];
  int          checked;
  int          mismatches;

  // Put every entry on the free list in ascending order
  task automatic clear_pool();
    free_stack.delete();
    alloc_order.delete();
    results_due.delete();
    for (int i = 0; i < ENTRIES; i++) begin
      free_stack.push_back(5'(i));
      entry_val[i] = '0;
    end
    entry_busy = '0;
    checked    = 0;
    mismatches = 0;
  endtask

  // Apply one request to the pool image and queue the results it causes
  task automatic predict_request(input req_t r);
    rsp_t       res;
    logic [4:0] id;
    res      = '0;
    res.last = 1'b1;
    id       = r.entry_id;
    case (cmd_e'(r.cmd))
      CMD_ALLOC: begin
        if (free_stack.size() == 0) begin
          res.status = ST_EXHAUSTED;
        end else begin
          id = free_stack.pop_front();
          entry_busy[id] = 1'b1;
          entry_val[id]  = r.data_value;
          alloc_order.push_back(id);
          res.status       = ST_OK;
          res.result_id    = id;
          res.stored_value = r.data_value;
        end
      end
      CMD_RELEASE, CMD_FIND, CMD_CHECK: begin
        res.result_id = id;
        if (!entry_busy[id]) begin
          res.status = ST_NOT_IN_USE;
        end else begin
          res.status       = ST_OK;
          res.stored_value = entry_val[id];
          if (cmd_e'(r.cmd) == CMD_RELEASE) begin
            // unlink from the in-use order, push on the free stack
            for (int i = 0; i < alloc_order.size(); i++) begin
              if (alloc_order[i] == id) begin
                alloc_order.delete(i);
                break;
              end
            end
            free_stack.push_front(id);
            entry_busy[id] = 1'b0;
          end else if (cmd_e'(r.cmd) == CMD_CHECK && r.value_ok) begin
            res.changed   = (r.data_value != entry_val[id]);
            entry_val[id] = r.data_value;
          end
        end
      end
      CMD_LIST: begin
        if (alloc_order.size() == 0) begin
          res.status = ST_LIST_EMPTY;
        end else begin
          // one result per in-use entry, oldest first
          foreach (alloc_order[i]) begin
            res              = '0;
            res.status       = ST_OK;
            res.result_id    = alloc_order[i];
            res.stored_value = entry_val[alloc_order[i]];
            res.last         = (i == alloc_order.size() - 1);
            results_due.push_back(res);
          end
          return;
        end
      end
      default: return;  // unused codes: drop silently
    endcase
    results_due.push_back(res);
  endtask

  // Compare one accepted result with the oldest one due
  task automatic compare_result(input rsp_t got);
    rsp_t exp;
    checked++;
    if (results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("Unexpected result: status %0d id %0d value %h changed %b last %b",
                 got.status, got.result_id, got.stored_value, got.changed, got.last);
      return;
    end
    exp = results_due.pop_front();
    if (got.status !== exp.status || got.result_id !== exp.result_id ||
        got.stored_value !== exp.stored_value || got.changed !== exp.changed ||
        got.last !== exp.last) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("Mismatch on result %0d:", checked);
        $display("  expected status %0d id %0d value %h changed %b last %b",
                 exp.status, exp.result_id, exp.stored_value, exp.changed, exp.last);
        $display("  actual   status %0d id %0d value %h changed %b last %b",
                 got.status, got.result_id, got.stored_value, got.changed, got.last);
      end
    end
  endtask

  // Track both channels; publish the counters as registered outputs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_pool();
    end else begin
      if (req_valid_i && !req_stall_i) predict_request(req_i);
      if (rsp_valid_i && !rsp_stall_i) compare_result(rsp_i);
    end
    busy_mask_o  <= entry_busy;
    pending_o    <= results_due.size();
    checked_o    <= checked;
    mismatches_o <= mismatches;
  end

endmodule

// File: sim/watch_entry_pool_manager_tb.sv
// ----------------------------------------------------------------------------
// watch_entry_pool_manager_tb
// Drives directed and random request streams into the watch entry pool
// manager with random gaps on both channels and gives the verdict from the
// checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module watch_entry_pool_manager_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wepm_pkg::*;

  localparam int          RANDOM_ITEMS   = 90;
  localparam int          FILL_RESERVE   = 20;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 40;
  localparam logic [2:0]  CMD_UNUSED_LO  = 3'd5;
  localparam logic [2:0]  CMD_UNUSED_HI  = 3'd7;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  req_t        in_req    = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_rsp;
  logic [31:0] busy_mask;
  int          pending;
  int          checked;
  int          mismatches;
  int          idle_cycles = 0;
  int          work_items  = 0;
  int          cmd_hits[8] = '{default: 0};
  int          send_calm   = 0;
  int          recv_calm   = 0;
  int          recv_hold   = 0;

  watch_entry_pool_manager uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  watch_entry_pool_manager_chk u_pool_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid),
    .req_stall_i  (in_stall),
    .req_i        (in_req),
    .rsp_valid_i  (out_valid),
    .rsp_stall_i  (out_stall),
    .rsp_i        (out_rsp),
    .busy_mask_o  (busy_mask),
    .pending_o    (pending),
    .checked_o    (checked),
    .mismatches_o (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result channel for a random count after each result,
  // with occasional runs of back-to-back acceptance
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (recv_calm != 0) begin
        recv_calm--;
        recv_hold = 0;
      end else if ($urandom_range(0, 7) == 0) begin
        recv_calm = $urandom_range(10, 30);
        recv_hold = 0;
      end else begin
        recv_hold = $urandom_range(0, 11);
      end
    end
    if (recv_hold != 0) begin
      out_stall <= 1'b1;
      recv_hold--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: nothing moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic req_t make_req(input logic [2:0] cmd, input logic [4:0] id,
                                    input logic [31:0] data, input logic ok);
    req_t r;
    r.cmd        = cmd;
    r.entry_id   = id;
    r.data_value = data;
    r.value_ok   = ok;
    return r;
  endfunction

  // Idle cycles before the next request, with runs of none
  function automatic int next_gap();
    if (send_calm != 0) begin
      send_calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      send_calm = $urandom_range(8, 16);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Mostly an entry currently in use, sometimes any id
  function automatic logic [4:0] pick_id(input logic [31:0] busy);
    int k;
    if (busy == '0 || $urandom_range(0, 99) < 15) return 5'($urandom_range(0, 31));
    k = $urandom_range(0, $countones(busy) - 1);
    for (int i = 0; i < 32; i++) begin
      if (busy[i]) begin
        if (k == 0) return 5'(i);
        k--;
      end
    end
    return 5'd0;
  endfunction

  // Favor a few recurring values so checks often see no change
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t random_request(input phase_e phase, input logic [31:0] busy);
    req_t r;
    int   pick;
    r.value_ok   = ($urandom_range(0, 3) != 0);
    r.data_value = pick_value();
    r.entry_id   = pick_id(busy);
    pick         = $urandom_range(0, 99);
    if (pick < 4) begin
      r.cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      return r;
    end
    pick = $urandom_range(0, 99);
    case (phase)
      PH_FILL:  r.cmd = (pick < 70) ? CMD_ALLOC : (pick < 78) ? CMD_RELEASE :
                        (pick < 86) ? CMD_FIND  : (pick < 95) ? CMD_CHECK : CMD_LIST;
      PH_DRAIN: r.cmd = (pick < 15) ? CMD_ALLOC : (pick < 60) ? CMD_RELEASE :
                        (pick < 72) ? CMD_FIND  : (pick < 88) ? CMD_CHECK : CMD_LIST;
      default:  r.cmd = (pick < 25) ? CMD_ALLOC : (pick < 45) ? CMD_RELEASE :
                        (pick < 62) ? CMD_FIND  : (pick < 85) ? CMD_CHECK : CMD_LIST;
    endcase
    return r;
  endfunction

  // Present one request after a random gap and hold it until taken
  task automatic issue(input req_t r);
    int gap;
    gap = next_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req   <= r;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    cmd_hits[r.cmd]++;
    if (r.cmd <= CMD_LIST) work_items++;
  endtask

  // Stop sending until every pending result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    phase_e phase;
    req_t   r;
    int     extra;
    int     phase_left;
    int     target;
    bit     paused;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Error cases on an empty pool
    issue(make_req(CMD_LIST, 5'd0, 32'h0, 1'b0));
    issue(make_req(CMD_FIND, 5'd0, 32'h0, 1'b1));
    issue(make_req(CMD_RELEASE, 5'd31, 32'hFFFF_FFFF, 1'b0));
    issue(make_req(CMD_CHECK, 5'd5, 32'h5555_5555, 1'b1));
    // Allocate with extreme values, then find and check
    issue(make_req(CMD_ALLOC, 5'($urandom), 32'h0000_0000, 1'b0));
    issue(make_req(CMD_ALLOC, 5'($urandom), 32'hFFFF_FFFF, 1'b1));
    issue(make_req(CMD_ALLOC, 5'($urandom), 32'h1234_5678, 1'b0));
    issue(make_req(CMD_ALLOC, 5'($urandom), 32'h8000_0001, 1'b1));
    issue(make_req(CMD_FIND, 5'd1, 32'h0, 1'b0));
    issue(make_req(CMD_CHECK, 5'd2, 32'hDEAD_BEEF, 1'b0));
    issue(make_req(CMD_CHECK, 5'd2, 32'h1234_5678, 1'b1));
    issue(make_req(CMD_CHECK, 5'd0, 32'hFFFF_FFFF, 1'b1));
    issue(make_req(CMD_LIST, 5'd0, 32'h0, 1'b0));
    // Release from the middle, head and tail of the in-use order
    issue(make_req(CMD_RELEASE, 5'd1, 32'h0, 1'b0));
    issue(make_req(CMD_RELEASE, 5'd0, 32'h0, 1'b1));
    issue(make_req(CMD_RELEASE, 5'd3, 32'h0, 1'b0));
    issue(make_req(CMD_LIST, 5'd0, 32'h0, 1'b1));
    // Reuse the most recently freed entry, double release
    issue(make_req(CMD_ALLOC, 5'($urandom), 32'hA5A5_A5A5, 1'b1));
    issue(make_req(CMD_RELEASE, 5'd2, 32'h0, 1'b0));
    issue(make_req(CMD_RELEASE, 5'd2, 32'h0, 1'b0));
    // Unused command codes
    for (int c = CMD_UNUSED_LO; c <= CMD_UNUSED_HI; c++)
      issue(make_req(3'(c), 5'($urandom), $urandom, 1'($urandom)));
    issue(make_req(CMD_LIST, 5'd0, 32'h0, 1'b0));
    issue(make_req(CMD_FIND, 5'd31, 32'hFFFF_FFFF, 1'b1));
    wait_for_drain();

    // Fill the pool and run into exhaustion a few times
    target = work_items + RANDOM_ITEMS;
    extra  = 0;
    while (extra < 3 && work_items < target - FILL_RESERVE) begin
      r = random_request(PH_FILL, busy_mask);
      if (&busy_mask) begin
        r.cmd = CMD_ALLOC;
        extra++;
      end
      issue(r);
    end

    // Random phases of filling, draining and mixed traffic
    paused     = 1'b0;
    phase_left = 0;
    phase      = PH_DRAIN;
    while (work_items < target) begin
      if (phase_left == 0) begin
        phase      = phase_e'($urandom_range(0, 2));
        phase_left = $urandom_range(10, 20);
      end
      if (!paused && work_items >= target - RANDOM_ITEMS / 3) begin
        wait_for_drain();
        paused = 1'b1;
      end
      issue(random_request(phase, busy_mask));
      phase_left--;
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests: %0d allocate, %0d release, %0d find, %0d check, %0d list",
             work_items, cmd_hits[CMD_ALLOC], cmd_hits[CMD_RELEASE], cmd_hits[CMD_FIND],
             cmd_hits[CMD_CHECK], cmd_hits[CMD_LIST]);
    $display("%0d unused codes sent, %0d results compared, %0d mismatches",
             cmd_hits[5] + cmd_hits[6] + cmd_hits[7], checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
